/* rtl/deq_pkg.sv */
// deq_pkg: shared codes, defaults and command type of the double-ended queue
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

	// fixed field widths
	localparam int FUNC_W   = 3;
	localparam int STATUS_W = 2;
	localparam int VALUE_W  = 32;

	// parameter defaults
	localparam int DEPTH_DEF     = 16;
	localparam int WORD_BITS_DEF = 32;

	// operation codes
	localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_PUSH_BACK  = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_POP_BACK   = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_REVERSE    = 3'd4;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR      = 3'd5;
	localparam logic [FUNC_W-1:0] FUNC_QUERY      = 3'd6;

	// status codes
	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

	// commands from controller to datapath
	typedef struct packed {
		logic take;   // capture the incoming word
		logic exec;   // apply the operation, write the slot
		logic read;   // read both ends of the queue
		logic load;   // load the output register
	} deq_cmd_t;

endpackage

`default_nettype wire

/* rtl/deq_ram.sv */
// deq_ram: generic RAM, one write port, two registered read ports
`timescale 1ns / 1ps
`default_nettype none

module deq_ram #(
	parameter int WIDTH = deq_pkg::WORD_BITS_DEF,
	parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_a,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read ports
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule

`default_nettype wire

/* rtl/deq_ctrl.sv */
// deq_ctrl: sequencing state machine of the double-ended queue
`timescale 1ns / 1ps
`default_nettype none

module deq_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output deq_pkg::deq_cmd_t     cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_READ = 2'd2;
	localparam logic [1:0] ST_LOAD = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	// command decode
	assign cmd.take = in_valid && (state_q == ST_IDLE);
	assign cmd.exec = (state_q == ST_EXEC);
	assign cmd.read = (state_q == ST_READ);
	assign cmd.load = (state_q == ST_LOAD) && out_free;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_EXEC;
			end
			ST_EXEC: state_d = ST_READ;
			ST_READ: state_d = ST_LOAD;
			ST_LOAD: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state and output word flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/deq_dp.sv */
// deq_dp: ring buffer pointers, slot memory and output register
`timescale 1ns / 1ps
`default_nettype none

module deq_dp #(
	parameter int DEPTH     = deq_pkg::DEPTH_DEF,
	parameter int WORD_BITS = deq_pkg::WORD_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire deq_pkg::deq_cmd_t                 cmd,
	input  wire logic [deq_pkg::FUNC_W-1:0]        func,
	input  wire logic signed [deq_pkg::VALUE_W-1:0] value,
	output logic [deq_pkg::STATUS_W-1:0]           status,
	output logic [$clog2(DEPTH+1)-1:0]             count,
	output logic                                   is_empty,
	output logic signed [deq_pkg::VALUE_W-1:0]     front_word,
	output logic signed [deq_pkg::VALUE_W-1:0]     back_word
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = CW + 1;
	localparam int KB = (WORD_BITS < deq_pkg::VALUE_W) ? WORD_BITS : deq_pkg::VALUE_W;
	localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

	logic [deq_pkg::FUNC_W-1:0]   func_q;
	logic [deq_pkg::VALUE_W-1:0]  value_q;
	logic [AW-1:0]                head_q;
	logic [CW-1:0]                fill_q;
	logic                         rev_q;
	logic [deq_pkg::STATUS_W-1:0] stat_q;

	logic [AW-1:0]                head_d;
	logic [CW-1:0]                fill_d;
	logic                         rev_d;
	logic [deq_pkg::STATUS_W-1:0] stat_d;
	logic                         we_c;
	logic [AW-1:0]                waddr_c;
	logic                         at_start;
	logic                         full_c;
	logic                         empty_c;
	logic [AW-1:0]                head_inc;
	logic [AW-1:0]                head_dec;
	logic [AW-1:0]                tail_idx;
	logic [AW-1:0]                last_idx;
	logic [WORD_BITS-1:0]         wdata;
	logic [WORD_BITS-1:0]         rdata_first;
	logic [WORD_BITS-1:0]         rdata_last;
	logic [deq_pkg::VALUE_W-1:0]  first_w;
	logic [deq_pkg::VALUE_W-1:0]  last_w;

	logic [deq_pkg::STATUS_W-1:0] status_q;
	logic [CW-1:0]                count_q;
	logic                         empty_q;
	logic [deq_pkg::VALUE_W-1:0]  front_q;
	logic [deq_pkg::VALUE_W-1:0]  back_q;

	// fold a sum below twice the depth back into the ring
	function automatic logic [AW-1:0] wrap_idx(input logic [SW-1:0] s);
		logic [SW-1:0] r;
		r = (s >= DEPTH_S) ? s - DEPTH_S : s;
		return r[AW-1:0];
	endfunction

	// ring index arithmetic
	assign full_c   = (fill_q == DEPTH_C);
	assign empty_c  = (fill_q == '0);
	assign head_inc = wrap_idx(SW'(head_q) + SW'(1));
	assign head_dec = (head_q == '0) ? LAST_IDX : head_q - AW'(1);
	assign tail_idx = wrap_idx(SW'(head_q) + SW'(fill_q));
	assign last_idx = empty_c ? head_q : wrap_idx(SW'(head_q) + SW'(fill_q) - SW'(1));
	assign wdata    = WORD_BITS'(value_q[KB-1:0]);

	// operation decode
	always_comb begin
		head_d   = head_q;
		fill_d   = fill_q;
		rev_d    = rev_q;
		stat_d   = deq_pkg::STATUS_OK;
		we_c     = 1'b0;
		waddr_c  = tail_idx;
		at_start = 1'b0;
		unique case (func_q) inside
			deq_pkg::FUNC_PUSH_FRONT, deq_pkg::FUNC_PUSH_BACK: begin
				at_start = (func_q == deq_pkg::FUNC_PUSH_FRONT) ^ rev_q;
				if (full_c) begin
					stat_d = deq_pkg::STATUS_FULL;
				end else begin
					we_c   = 1'b1;
					fill_d = fill_q + CW'(1);
					if (at_start) begin
						head_d  = head_dec;
						waddr_c = head_dec;
					end
				end
			end
			deq_pkg::FUNC_POP_FRONT, deq_pkg::FUNC_POP_BACK: begin
				at_start = (func_q == deq_pkg::FUNC_POP_FRONT) ^ rev_q;
				if (empty_c) begin
					stat_d = deq_pkg::STATUS_EMPTY;
				end else begin
					fill_d = fill_q - CW'(1);
					if (at_start) head_d = head_inc;
				end
			end
			deq_pkg::FUNC_REVERSE: rev_d = !rev_q;
			deq_pkg::FUNC_CLEAR:   fill_d = '0;
			default: ;
		endcase
	end

	// captured word
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			func_q  <= func;
			value_q <= value;
		end
		if (cmd.exec) begin
			stat_q <= stat_d;
		end
	end

	// queue pointers and direction flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			fill_q <= '0;
			rev_q  <= 1'b0;
		end else if (cmd.exec) begin
			head_q <= head_d;
			fill_q <= fill_d;
			rev_q  <= rev_d;
		end
	end

	// slot memory
	deq_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.we      (cmd.exec && we_c),
		.waddr   (waddr_c),
		.wdata   (wdata),
		.re      (cmd.read),
		.raddr_a (head_q),
		.raddr_b (last_idx),
		.rdata_a (rdata_first),
		.rdata_b (rdata_last)
	);

	assign first_w = deq_pkg::VALUE_W'(rdata_first[KB-1:0]);
	assign last_w  = deq_pkg::VALUE_W'(rdata_last[KB-1:0]);

	// output register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			status_q <= stat_q;
			count_q  <= fill_q;
			empty_q  <= empty_c;
			front_q  <= empty_c ? '0 : (rev_q ? last_w : first_w);
			back_q   <= empty_c ? '0 : (rev_q ? first_w : last_w);
		end
	end

	assign status     = status_q;
	assign count      = count_q;
	assign is_empty   = empty_q;
	assign front_word = front_q;
	assign back_word  = back_q;

endmodule

`default_nettype wire

/* rtl/double_ended_queue.sv */
// double_ended_queue: top level of the ring-buffer double-ended queue
// Steps per word: capture, update and slot write, read of both ends from the
// slot memory, output load; the load waits while a held result is stalled.
// A new word is accepted only once the last one has reached the output
// register, which lets the next word be accepted while a result still waits.
// Reset: arst_n clears pointers, fill count, direction flag, controller and
// output valid at once; the slot memory and output register are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue #(
	parameter int DEPTH     = deq_pkg::DEPTH_DEF,
	parameter int WORD_BITS = deq_pkg::WORD_BITS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic [deq_pkg::FUNC_W-1:0]         func,
	input  wire logic signed [deq_pkg::VALUE_W-1:0] value,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic [deq_pkg::STATUS_W-1:0]            status,
	output logic [$clog2(DEPTH+1)-1:0]              count,
	output logic                                    is_empty,
	output logic signed [deq_pkg::VALUE_W-1:0]      front_word,
	output logic signed [deq_pkg::VALUE_W-1:0]      back_word
);

	deq_pkg::deq_cmd_t cmd;

	// controller
	deq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	// datapath
	deq_dp #(
		.DEPTH     (DEPTH),
		.WORD_BITS (WORD_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.func       (func),
		.value      (value),
		.status     (status),
		.count      (count),
		.is_empty   (is_empty),
		.front_word (front_word),
		.back_word  (back_word)
	);

`ifndef SYNTH
	// an accepted word is applied in the following cycle
	a_take_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> cmd.exec)
		else $error("accepted word not applied");

	// count never exceeds the depth
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (count <= ($clog2(DEPTH+1))'(DEPTH)))
		else $error("count above depth");

	// empty flag agrees with count
	a_empty_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (is_empty == (count == '0)))
		else $error("empty flag and count disagree");

	// empty queue reports zero end words
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && is_empty) |-> (front_word == '0 && back_word == '0))
		else $error("end words not zero on empty queue");
`endif

endmodule

`default_nettype wire

/* test/tb_top.sv */
// tb_top: self-checking testbench of the ring-buffer double-ended queue
`timescale 1ns / 1ps

module tb_top;
	import deq_pkg::*;

	localparam int DEPTH   = DEPTH_DEF;
	localparam int PTR_W   = $clog2(DEPTH);
	localparam int COUNT_W = $clog2(DEPTH + 1);

	// the one code the package leaves unnamed, handled as a query
	localparam logic [FUNC_W-1:0] FUNC_SPARE = 3'd7;

	localparam logic signed [VALUE_W-1:0] WORD_MAX = 32'sh7fff_ffff;
	localparam logic signed [VALUE_W-1:0] WORD_MIN = 32'sh8000_0000;

	// traffic mixes of the random phases
	typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED} op_mix_t;

	// queue state seen after one operation
	typedef struct {
		logic [STATUS_W-1:0]       status;
		logic [COUNT_W-1:0]        count;
		logic                      is_empty;
		logic signed [VALUE_W-1:0] front_word;
		logic signed [VALUE_W-1:0] back_word;
	} deque_view_t;

	// tracks the queue contents and the views still owed by the block
	class deque_scoreboard;
		logic signed [VALUE_W-1:0] ring [DEPTH];
		logic [PTR_W-1:0]          head;
		logic [COUNT_W-1:0]        fill;
		logic                      flipped;
		deque_view_t               owed_views [$];
		int                        errors;

		function new();
			head    = '0;
			fill    = '0;
			flipped = 1'b0;
			errors  = 0;
		endfunction

		function int pending();
			return owed_views.size();
		endfunction

		task report(input string msg);
			$display("tb: mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		// apply one accepted word and queue the view it should produce
		function void note_word(input logic [FUNC_W-1:0] op, input logic signed [VALUE_W-1:0] v);
			logic                      at_start;
			logic [PTR_W-1:0]          idx;
			logic signed [VALUE_W-1:0] first;
			logic signed [VALUE_W-1:0] last;
			deque_view_t               view;

			view.status = STATUS_OK;
			case (op)
				FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
					// physical start is the logical front unless flipped
					at_start = (op == FUNC_PUSH_FRONT) ? !flipped : flipped;
					if (fill >= DEPTH) begin
						view.status = STATUS_FULL;
					end else begin
						if (at_start) begin
							head = head - 1'b1;
							ring[head] = v;
						end else begin
							idx = head + fill[PTR_W-1:0];
							ring[idx] = v;
						end
						fill = fill + 1'b1;
					end
				end
				FUNC_POP_FRONT, FUNC_POP_BACK: begin
					at_start = (op == FUNC_POP_FRONT) ? !flipped : flipped;
					if (fill == 0) begin
						view.status = STATUS_EMPTY;
					end else begin
						if (at_start)
							head = head + 1'b1;
						fill = fill - 1'b1;
					end
				end
				FUNC_REVERSE: flipped = !flipped;
				FUNC_CLEAR:   fill = '0;
				default: ;
			endcase

			// both ends read as zero while empty
			first = '0;
			last  = '0;
			if (fill != 0) begin
				first = ring[head];
				idx   = head + fill[PTR_W-1:0] - 1'b1;
				last  = ring[idx];
			end
			view.count      = fill;
			view.is_empty   = (fill == 0);
			view.front_word = flipped ? last : first;
			view.back_word  = flipped ? first : last;
			owed_views.insert(owed_views.size(), view);
		endfunction

		// compare one accepted result with the oldest owed view
		task check_word(input logic [STATUS_W-1:0] st, input logic [COUNT_W-1:0] cnt,
			input logic emp, input logic signed [VALUE_W-1:0] fw,
			input logic signed [VALUE_W-1:0] bw);
			deque_view_t view;

			if (owed_views.size() == 0) begin
				report("result word with nothing pending");
				return;
			end
			view = owed_views[0];
			owed_views.delete(0);
			if (st !== view.status)
				report($sformatf("status %0d, want %0d", st, view.status));
			if (cnt !== view.count)
				report($sformatf("count %0d, want %0d", cnt, view.count));
			if (emp !== view.is_empty)
				report($sformatf("is_empty %0b, want %0b", emp, view.is_empty));
			if (fw !== view.front_word)
				report($sformatf("front_word %0d, want %0d", fw, view.front_word));
			if (bw !== view.back_word)
				report($sformatf("back_word %0d, want %0d", bw, view.back_word));
		endtask
	endclass

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_stall;
	logic [FUNC_W-1:0]         func;
	logic signed [VALUE_W-1:0] value;
	logic                      out_valid;
	logic                      out_stall;
	logic [STATUS_W-1:0]       status;
	logic [COUNT_W-1:0]        count;
	logic                      is_empty;
	logic signed [VALUE_W-1:0] front_word;
	logic signed [VALUE_W-1:0] back_word;

	deque_scoreboard sb = new();
	bit              calm;
	int              words_sent;

	double_ended_queue DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.func       (func),
		.value      (value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.count      (count),
		.is_empty   (is_empty),
		.front_word (front_word),
		.back_word  (back_word)
	);

	// 50 MHz clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// present one word after a random gap and hold it until taken
	task automatic send_word(input logic [FUNC_W-1:0] op, input logic signed [VALUE_W-1:0] v);
		int gap;

		gap = calm ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		func     <= op;
		value    <= v;
		do @(posedge clk); while (in_stall);
		sb.note_word(op, v);
		words_sent++;
		@(negedge clk);
	endtask

	// extremes show up often, the rest is plain random
	function automatic logic signed [VALUE_W-1:0] pick_word();
		case ($urandom_range(0, 9))
			0:       return WORD_MAX;
			1:       return WORD_MIN;
			2:       return '0;
			3:       return -1;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [FUNC_W-1:0] pick_op(input op_mix_t mix);
		int push_w;
		int pop_w;
		int r;

		case (mix)
			MIX_FILL:  begin push_w = 66; pop_w = 18; end
			MIX_DRAIN: begin push_w = 18; pop_w = 66; end
			default:   begin push_w = 42; pop_w = 42; end
		endcase
		r = $urandom_range(0, 99);
		if (r < push_w)
			return $urandom_range(0, 1) ? FUNC_PUSH_FRONT : FUNC_PUSH_BACK;
		if (r < push_w + pop_w)
			return $urandom_range(0, 1) ? FUNC_POP_FRONT : FUNC_POP_BACK;
		if (r < push_w + pop_w + 8)
			return FUNC_REVERSE;
		if (r < push_w + pop_w + 12)
			return FUNC_QUERY;
		if (r < push_w + pop_w + 14)
			return FUNC_SPARE;
		return FUNC_CLEAR;
	endfunction

	// result side: random stall per word, then take the next result
	initial begin
		int hold;

		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			hold = calm ? 0 : $urandom_range(0, 12);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			sb.check_word(status, count, is_empty, front_word, back_word);
		end
	end

	// reset, directed words, random phases, drain
	initial begin
		op_mix_t mix;
		int      len;
		int      settle;

		arst_n     = 1'b0;
		in_valid   = 1'b0;
		func       = FUNC_QUERY;
		value      = '0;
		calm       = 1'b0;
		words_sent = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty queue corners, then both ends and direction flips
		send_word(FUNC_QUERY, '0);
		send_word(FUNC_SPARE, WORD_MAX);
		send_word(FUNC_POP_FRONT, '0);
		send_word(FUNC_POP_BACK, -1);
		send_word(FUNC_REVERSE, '0);
		send_word(FUNC_REVERSE, '0);
		send_word(FUNC_PUSH_FRONT, WORD_MAX);
		send_word(FUNC_PUSH_BACK, WORD_MIN);
		send_word(FUNC_PUSH_FRONT, -1);
		send_word(FUNC_PUSH_BACK, '0);
		send_word(FUNC_QUERY, WORD_MIN);
		send_word(FUNC_REVERSE, '0);
		send_word(FUNC_POP_FRONT, '0);
		send_word(FUNC_PUSH_FRONT, 32'sh5555_5555);
		send_word(FUNC_PUSH_BACK, 32'shaaaa_aaaa);
		send_word(FUNC_POP_BACK, '0);
		send_word(FUNC_SPARE, '0);
		// clear keeps the flipped direction
		send_word(FUNC_CLEAR, '0);
		send_word(FUNC_POP_BACK, '0);
		send_word(FUNC_PUSH_BACK, 32'sd1);
		send_word(FUNC_PUSH_FRONT, 32'sd2);
		send_word(FUNC_CLEAR, '0);
		send_word(FUNC_REVERSE, '0);

		// random phases, each with its own traffic mix
		while (words_sent < 600) begin
			case ($urandom_range(0, 2))
				0:       mix = MIX_FILL;
				1:       mix = MIX_DRAIN;
				default: mix = MIX_BALANCED;
			endcase
			calm = ($urandom_range(0, 3) == 0);
			len  = $urandom_range(20, 50);
			repeat (len) send_word(pick_op(mix), pick_word());
		end
		calm = 1'b0;
		in_valid <= 1'b0;

		// wait for the owed results, then a few more cycles for strays
		while (sb.pending() != 0)
			@(posedge clk);
		settle = 20;
		repeat (settle) @(posedge clk);
		if (sb.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// watchdog
	initial begin
		#4_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule
